FILE: sv/vqs_pkg.sv
// ----------------------------------------------------------------------------
// vqs_pkg
// Shared types and constants for the vector quantizer search core.
// ----------------------------------------------------------------------------
package vqs_pkg;

  localparam int COMP_BITS    = 16;            // signed q13 component
  localparam int SQ_W         = 2 * COMP_BITS; // one squared difference
  localparam int IN_COMPS     = 4;             // components carried on the stream
  localparam int ADDR_BITS    = 7;             // entry_addr field
  localparam int INDEX_BITS   = 7;             // best_index field
  localparam int DIM_REG_BITS = 3;
  localparam int CNT_REG_BITS = 8;
  localparam int DIM_CMP_BITS = 4;             // holds any dimension up to 8
  localparam int TDATA_BITS   = 72;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic REG_VECTOR_DIM = 1'b0;
  localparam logic REG_ENTRIES    = 1'b1;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_QUANTIZE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } vqs_state_t;

  // control travelling down the cell chain alongside each entry
  typedef struct packed {
    logic valid;
    logic last;
  } vqs_ctl_t;

endpackage

FILE: sv/vector_quantizer_search_core.sv
// ----------------------------------------------------------------------------
// vector_quantizer_search_core
// Full-search nearest-neighbour vector quantizer over a loadable codebook.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser selects the action. A load beat (tuser 0) writes
// comp0..comp3 into codebook entry entry_addr and gives no
// output beat. A quantize beat (tuser 1) searches entries 0..entries_in_use-1
// over vector_dim components and gives one output beat with the index of the
// nearest entry (lowest index on a tie) and that entry's components, zero
// beyond vector_dim. Both settings are clamped into their legal range.
// A search reads the codebook memory one entry per cycle; each entry passes a
// chain of MAX_DIM cells, one cell per component, then a compare stage and
// the output register. The next input beat is taken once the result has
// been loaded into the output register.
// Input is taken only between searches; a finished result sits in an output
// register, so the next beat is accepted while it waits. If the receiver
// still stalls when the next search finishes, the block holds until it drains.
// Reset clears control and sets vector_dim to 4 and entries_in_use to 128;
// the codebook is not cleared and entries must be loaded before use.
// Registers on the apb port: vector_dim at 0x0, entries_in_use at 0x4.
// ----------------------------------------------------------------------------
module vector_quantizer_search_core
  import vqs_pkg::*;
#(
  parameter int MAX_ENTRIES = 128,
  parameter int MAX_DIM     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_addr, comp0, comp1, comp2, comp3, zero pad
  input  logic [TDATA_BITS-1:0] s_axis_tdata,
  // action
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // best_index, quant0, quant1, quant2, quant3, zero pad
  output logic [TDATA_BITS-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int NW      = (CNT_W > CNT_REG_BITS) ? CNT_W : CNT_REG_BITS;
  localparam int DIST_W  = SQ_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);
  localparam int ENTRY_W = MAX_DIM * COMP_BITS;

  // configuration
  logic [DIM_REG_BITS-1:0] vector_dim;
  logic [CNT_REG_BITS-1:0] entries_in_use;
  logic                    cfg_we;
  logic [DIM_CMP_BITS-1:0] dim_eff;
  logic [NW-1:0]           n_eff;
  logic [IDX_W-1:0]        last_idx;
  logic [MAX_DIM-1:0]      active;

  // control
  vqs_state_t       state, state_next;
  logic             in_beat;
  logic             load_we;
  logic             start;
  logic [IDX_W-1:0] scan_addr;
  logic             have;
  logic             out_load;
  logic             out_valid;

  // input unpacking
  logic signed [COMP_BITS-1:0] in_comp [IN_COMPS];
  logic [ADDR_BITS-1:0]        in_addr;
  logic [ADDR_BITS-1:0]        wrap_addr;
  logic [IDX_W-1:0]            wr_addr;
  logic [ENTRY_W-1:0]          load_word;
  logic signed [COMP_BITS-1:0] vec_comp [MAX_DIM];

  // codebook memory
  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_idx;
  vqs_ctl_t           rd_ctl;

  // cell chain taps
  vqs_ctl_t           ctl_tap   [MAX_DIM+1];
  logic [IDX_W-1:0]   idx_tap   [MAX_DIM+1];
  logic [ENTRY_W-1:0] entry_tap [MAX_DIM+1];
  logic [DIST_W-1:0]  sum_tap   [MAX_DIM+1];

  // best so far
  logic [DIST_W-1:0]  best_dist;
  logic [IDX_W-1:0]   best_idx;
  logic [ENTRY_W-1:0] best_entry;
  logic signed [COMP_BITS-1:0] quant [IN_COMPS];
  logic [TDATA_BITS-1:0] out_data;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_dim     <= DIM_REG_BITS'(4);
      entries_in_use <= CNT_REG_BITS'(128);
    end else if (cfg_we) begin
      case (paddr[2])
        REG_VECTOR_DIM: vector_dim     <= pwdata[DIM_REG_BITS-1:0];
        REG_ENTRIES:    entries_in_use <= pwdata[CNT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VECTOR_DIM: prdata = APB_DATA_W'(vector_dim);
      REG_ENTRIES:    prdata = APB_DATA_W'(entries_in_use);
      default:        prdata = '0;
    endcase
  end

  // out-of-range settings are clamped into the legal range
  always_comb begin
    if (vector_dim == '0) begin
      dim_eff = DIM_CMP_BITS'(1);
    end else if (DIM_CMP_BITS'(vector_dim) > DIM_CMP_BITS'(MAX_DIM)) begin
      dim_eff = DIM_CMP_BITS'(MAX_DIM);
    end else begin
      dim_eff = DIM_CMP_BITS'(vector_dim);
    end
    if (entries_in_use == '0) begin
      n_eff = NW'(1);
    end else if (NW'(entries_in_use) > NW'(MAX_ENTRIES)) begin
      n_eff = NW'(MAX_ENTRIES);
    end else begin
      n_eff = NW'(entries_in_use);
    end
  end

  assign last_idx = IDX_W'(n_eff - NW'(1));

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_active
    assign active[c] = DIM_CMP_BITS'(c) < dim_eff;
  end

  // ---------------------------------------------------------------- input
  assign in_addr = s_axis_tdata[ADDR_BITS-1:0];
  for (genvar c = 0; c < IN_COMPS; c++) begin : g_in
    assign in_comp[c] = s_axis_tdata[ADDR_BITS + c*COMP_BITS +: COMP_BITS];
  end

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_vec
    if (c < IN_COMPS) begin : g_from_in
      assign vec_comp[c] = in_comp[c];
    end else begin : g_zero
      assign vec_comp[c] = '0;
    end
    assign load_word[c*COMP_BITS +: COMP_BITS] = vec_comp[c];
  end

  // address wrap by restoring remainder against shifted entry counts
  always_comb begin
    wrap_addr = in_addr;
    for (int k = ADDR_BITS - 1; k >= 0; k--) begin
      if ((MAX_ENTRIES << k) < (1 << ADDR_BITS)) begin
        if (wrap_addr >= ADDR_BITS'(MAX_ENTRIES << k)) begin
          wrap_addr = wrap_addr - ADDR_BITS'(MAX_ENTRIES << k);
        end
      end
    end
  end

  assign wr_addr = IDX_W'(wrap_addr);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign load_we       = in_beat && (s_axis_tuser == ACT_LOAD);
  assign start         = in_beat && (s_axis_tuser == ACT_QUANTIZE);

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_addr == last_idx) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (ctl_tap[MAX_DIM].valid && ctl_tap[MAX_DIM].last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_addr <= '0;
      rd_ctl    <= '0;
      out_valid <= 1'b0;
    end else begin
      state         <= state_next;
      rd_ctl.valid  <= (state == ST_SCAN);
      rd_ctl.last   <= (scan_addr == last_idx);
      if (start) begin
        scan_addr <= '0;
      end else if (state == ST_SCAN) begin
        scan_addr <= scan_addr + IDX_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[wr_addr] <= load_word;
    end
    rd_data <= mem[scan_addr];
    rd_idx  <= scan_addr;
  end

  // ---------------------------------------------------------------- cell chain
  assign ctl_tap[0]   = rd_ctl;
  assign idx_tap[0]   = rd_idx;
  assign entry_tap[0] = rd_data;
  assign sum_tap[0]   = '0;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    vqs_cell #(
      .POS    (c),
      .DIM    (MAX_DIM),
      .IDX_W  (IDX_W),
      .DIST_W (DIST_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .vec_load  (start),
      .vec_in    (vec_comp[c]),
      .active    (active[c]),
      .in_ctl    (ctl_tap[c]),
      .in_idx    (idx_tap[c]),
      .in_entry  (entry_tap[c]),
      .in_sum    (sum_tap[c]),
      .out_ctl   (ctl_tap[c+1]),
      .out_idx   (idx_tap[c+1]),
      .out_entry (entry_tap[c+1]),
      .out_sum   (sum_tap[c+1])
    );
  end

  // ---------------------------------------------------------------- compare
  // strict less-than keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (start) begin
      have <= 1'b0;
    end else if (ctl_tap[MAX_DIM].valid) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_tap[MAX_DIM].valid && (!have || (sum_tap[MAX_DIM] < best_dist))) begin
      best_dist  <= sum_tap[MAX_DIM];
      best_idx   <= idx_tap[MAX_DIM];
      best_entry <= entry_tap[MAX_DIM];
    end
  end

  // ---------------------------------------------------------------- output
  for (genvar c = 0; c < IN_COMPS; c++) begin : g_quant
    if (c < MAX_DIM) begin : g_used
      assign quant[c] = active[c] ? best_entry[c*COMP_BITS +: COMP_BITS] : '0;
    end else begin : g_unused
      assign quant[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= TDATA_BITS'({quant[3], quant[2], quant[1], quant[0],
                               INDEX_BITS'(best_idx)});
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // ---------------------------------------------------------------- checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_addr <= last_idx))
    else $error("scan address beyond last entry in use");

  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    (ctl_tap[MAX_DIM].valid && ctl_tap[MAX_DIM].last) |-> (state == ST_DRAIN))
    else $error("last entry left the chain outside drain");

  a_done_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> have)
    else $error("result issued with no entry compared");

endmodule

FILE: sv/vqs_cell.sv
// ----------------------------------------------------------------------------
// vqs_cell
// One cell of the distance chain: holds one vector component, squares its
// difference to the passing entry and adds it to the running distance.
// ----------------------------------------------------------------------------
module vqs_cell
  import vqs_pkg::*;
#(
  parameter int POS    = 0,
  parameter int DIM    = 4,
  parameter int IDX_W  = 7,
  parameter int DIST_W = 34
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vec_load,
  input  logic signed [COMP_BITS-1:0] vec_in,
  input  logic                        active,
  input  vqs_ctl_t                    in_ctl,
  input  logic [IDX_W-1:0]            in_idx,
  input  logic [DIM*COMP_BITS-1:0]    in_entry,
  input  logic [DIST_W-1:0]           in_sum,
  output vqs_ctl_t                    out_ctl,
  output logic [IDX_W-1:0]            out_idx,
  output logic [DIM*COMP_BITS-1:0]    out_entry,
  output logic [DIST_W-1:0]           out_sum
);

  logic signed [COMP_BITS-1:0] vec_comp;
  logic signed [COMP_BITS-1:0] sel;
  logic signed [COMP_BITS:0]   diff;
  logic signed [2*COMP_BITS+1:0] prod;
  logic [SQ_W-1:0]             sq;

  vqs_ctl_t                    ctl;
  logic [IDX_W-1:0]            idx;
  logic [DIM*COMP_BITS-1:0]    entry;
  logic [DIST_W-1:0]           sum;
  logic [SQ_W-1:0]             sq_reg;

  assign sel  = in_entry[POS*COMP_BITS +: COMP_BITS];
  assign diff = {vec_comp[COMP_BITS-1], vec_comp} - {sel[COMP_BITS-1], sel};
  assign prod = diff * diff;
  // a square of a 17 bit difference always fits in 32 unsigned bits
  assign sq   = active ? prod[SQ_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (vec_load) begin
      vec_comp <= vec_in;
    end
    idx    <= in_idx;
    entry  <= in_entry;
    sum    <= in_sum;
    sq_reg <= sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= in_ctl;
    end
  end

  assign out_ctl   = ctl;
  assign out_idx   = idx;
  assign out_entry = entry;
  assign out_sum   = sum + DIST_W'(sq_reg);

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the vector quantizer search core against its own nearest-entry
// predictor. Codebook loads and quantize beats are driven over the input
// stream, both sides idle in random bursts, and each output beat is compared
// field by field with the oldest predicted result. The entry count and the
// dimension are swept over the apb port, out-of-range values among them.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vqs_pkg::*;

  localparam int N_ENTRIES      = 128;
  localparam int N_DIM          = 4;
  localparam int SEARCH_LATENCY = N_ENTRIES + N_DIM + 12;
  localparam int LONG_HOLD      = 1200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [APB_ADDR_W-1:0] ADDR_DIM     = {REG_VECTOR_DIM, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_ENTRIES = {REG_ENTRIES, 2'b00};

  typedef struct packed {
    logic             act;
    logic [6:0]       addr;
    logic [3:0][15:0] comp;
  } vq_beat_t;

  typedef struct packed {
    logic [6:0]       index;
    logic [3:0][15:0] quant;
  } vq_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // entry_addr, comp0, comp1, comp2, comp3, zero pad
  logic [TDATA_BITS-1:0] s_axis_tdata = '0;
  // action
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // best_index, quant0, quant1, quant2, quant3, zero pad
  logic [TDATA_BITS-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  vector_quantizer_search_core #(
    .MAX_ENTRIES(N_ENTRIES),
    .MAX_DIM    (N_DIM)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, updated as beats and register writes are accepted
  logic [3:0][15:0]        codebook_copy [N_ENTRIES];
  logic [DIM_REG_BITS-1:0] cfg_dim;
  logic [CNT_REG_BITS-1:0] cfg_entries;
  vq_result_t              result_q [$];

  // generator view of the codebook, ahead of the predictor by the queued beats
  logic [3:0][15:0] gen_book [N_ENTRIES];
  int               gen_cnt = N_ENTRIES;
  vq_beat_t         stim_q [$];

  bit in_beat_done = 1'b0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit calm = 1'b0;
  int tx_gap = 0;
  int rx_wait = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int n_loads = 0;
  int n_quant = 0;
  int n_results = 0;
  int n_settings = 0;

  function automatic vq_result_t nearest_entry(logic [3:0][15:0] v);
    vq_result_t r;
    int         dim;
    int         cnt;
    int         best;
    longint     best_d;
    longint     d;
    longint     diff;
    dim = cfg_dim;
    if (dim < 1) dim = 1;
    if (dim > N_DIM) dim = N_DIM;
    cnt = cfg_entries;
    if (cnt < 1) cnt = 1;
    if (cnt > N_ENTRIES) cnt = N_ENTRIES;
    best = 0;
    best_d = 0;
    for (int e = 0; e < cnt; e++) begin
      d = 0;
      for (int c = 0; c < dim; c++) begin
        diff = longint'($signed(v[c])) - longint'($signed(codebook_copy[e][c]));
        d += diff * diff;
      end
      // strict compare keeps the lowest index on a tie
      if (e == 0 || d < best_d) begin
        best_d = d;
        best = e;
      end
    end
    r.index = best[6:0];
    for (int c = 0; c < 4; c++) begin
      r.quant[c] = (c < dim) ? codebook_copy[best][c] : 16'h0000;
    end
    return r;
  endfunction

  function automatic string fmt_result(vq_result_t r);
    return $sformatf("index %0d quant %0d %0d %0d %0d", r.index, $signed(r.quant[0]),
                     $signed(r.quant[1]), $signed(r.quant[2]), $signed(r.quant[3]));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // sampling side: register writes, output checks, input prediction, watchdog
  always @(posedge clk) begin : sample_proc
    vq_result_t got;
    vq_result_t want;
    vq_beat_t   b;
    bit         any_beat;
    if (rst) begin
      cfg_dim = 3'd4;
      cfg_entries = 8'd128;
      in_beat_done = 1'b0;
      quiet_cycles = 0;
    end else begin
      any_beat = 1'b0;
      if (psel && penable && pwrite && pready) begin
        any_beat = 1'b1;
        if (paddr == ADDR_DIM) cfg_dim = pwdata[DIM_REG_BITS-1:0];
        else if (paddr == ADDR_ENTRIES) cfg_entries = pwdata[CNT_REG_BITS-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        any_beat = 1'b1;
        n_results++;
        got.index = m_axis_tdata[6:0];
        got.quant = m_axis_tdata[70:7];
        if (result_q.size() == 0) begin
          note_mismatch({"unexpected beat: ", fmt_result(got)});
        end else begin
          want = result_q.pop_front();
          if (got != want)
            note_mismatch({"expected ", fmt_result(want), ", got ", fmt_result(got)});
        end
      end
      in_beat_done = s_axis_tvalid && s_axis_tready;
      if (in_beat_done) begin
        any_beat = 1'b1;
        b.act = s_axis_tuser;
        b.addr = s_axis_tdata[6:0];
        b.comp = s_axis_tdata[70:7];
        if (b.act == ACT_LOAD) begin
          codebook_copy[b.addr] = b.comp;
          n_loads++;
        end else begin
          result_q.push_back(nearest_entry(b.comp));
          n_quant++;
        end
      end
      quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // input driver
  always @(negedge clk) begin : drive_proc
    vq_beat_t b;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_beat_done) begin
      // beat still on offer
    end else if (tx_gap > 0) begin
      tx_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (tx_idle_on && !calm && $urandom_range(0, 7) == 0) begin
      tx_gap = $urandom_range(1, 10) - 1;
      s_axis_tvalid <= 1'b0;
    end else if (stim_q.size() != 0) begin
      b = stim_q.pop_front();
      s_axis_tdata <= {1'b0, b.comp, b.addr};
      s_axis_tuser <= b.act;
      s_axis_tvalid <= 1'b1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      rx_wait = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && !calm && $urandom_range(0, 5) == 0) begin
      rx_wait = $urandom_range(1, 10) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [3:0][15:0] vec4(int c0, int c1, int c2, int c3);
    return {16'(c3), 16'(c2), 16'(c1), 16'(c0)};
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [3:0][15:0] rand_vector();
    return {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
  endfunction

  // search probe: an exact entry, a near miss around one, or anything at all
  function automatic logic [3:0][15:0] probe_vector();
    logic [3:0][15:0] v;
    v = gen_book[$urandom_range(0, gen_cnt - 1)];
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4: begin
        for (int c = 0; c < 4; c++) v[c] = v[c] + 16'($urandom_range(0, 8)) - 16'd4;
      end
      default: v = rand_vector();
    endcase
    return v;
  endfunction

  task automatic push_load(input logic [6:0] addr, input logic [3:0][15:0] v);
    vq_beat_t b;
    b.act = ACT_LOAD;
    b.addr = addr;
    b.comp = v;
    stim_q.push_back(b);
    gen_book[addr] = v;
  endtask

  task automatic push_quantize(input logic [3:0][15:0] v);
    vq_beat_t b;
    b.act = ACT_QUANTIZE;
    b.addr = 7'($urandom());
    b.comp = v;
    stim_q.push_back(b);
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= '0;
  endtask

  // only the low register bits count, so the rest of pwdata carries noise
  task automatic set_config(input int dim, input int cnt);
    write_reg(ADDR_DIM, ($urandom() << DIM_REG_BITS) | 32'(dim));
    write_reg(ADDR_ENTRIES, ($urandom() << CNT_REG_BITS) | 32'(cnt));
    gen_cnt = (cnt < 1) ? 1 : (cnt > N_ENTRIES) ? N_ENTRIES : cnt;
    n_settings++;
  endtask

  // wait until nothing is in flight, then let a late search finish
  task automatic settle();
    do @(posedge clk); while (stim_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
    repeat (SEARCH_LATENCY) @(posedge clk);
  endtask

  task automatic random_phase(input int dim, input int cnt, input int items, input bit hold);
    logic [6:0]       a;
    logic [3:0][15:0] v;
    set_config(dim, cnt);
    tx_idle_on = $urandom_range(0, 3) != 0;
    rx_idle_on = $urandom_range(0, 3) != 0;
    if (hold) holds_asked++;
    for (int i = 0; i < items; i++) begin
      if (!hold && $urandom_range(0, 3) == 0) begin
        a = $urandom_range(0, 1) ? 7'($urandom_range(0, gen_cnt - 1)) : 7'($urandom());
        // copies of other entries give ties for the index compare
        v = ($urandom_range(0, 2) == 0) ? gen_book[$urandom_range(0, N_ENTRIES - 1)]
                                        : rand_vector();
        push_load(a, v);
      end else begin
        push_quantize(probe_vector());
      end
    end
    settle();
  endtask

  initial begin : stimulus_proc
    int order [N_ENTRIES];
    int j;
    int t;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, ties and the register corner cases on a small codebook
    set_config(4, 4);
    push_load(0, vec4(32767, 32767, 32767, 32767));
    push_load(1, vec4(-32768, -32768, -32768, -32768));
    push_load(2, vec4(0, 0, 0, 0));
    push_load(3, vec4(0, 0, 0, 0));
    push_quantize(vec4(-32768, -32768, -32768, -32768));
    push_quantize(vec4(32767, 32767, 32767, 32767));
    push_quantize(vec4(0, 0, 0, 0));
    push_quantize(vec4(-1, -1, -1, -1));
    push_quantize(vec4(32767, -32768, 32767, -32768));
    push_load(127, vec4(16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    push_load(126, vec4(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    settle();
    set_config(1, 4);
    push_quantize(vec4(100, 32767, -32768, 5));
    // a load at dimension one still stores all four components
    push_load(3, vec4(0, 1234, -1234, 77));
    settle();
    set_config(4, 4);
    push_quantize(vec4(0, 1234, -1234, 77));
    settle();
    set_config(0, 0);
    push_quantize(vec4(-5, 300, -300, 9));
    settle();
    set_config(7, 1);
    push_quantize(vec4(20000, -20000, 1, -1));
    settle();

    // fill the whole codebook in a shuffled order
    set_config(4, 128);
    for (int i = 0; i < N_ENTRIES; i++) order[i] = i;
    for (int i = N_ENTRIES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (i > 0 && $urandom_range(0, 4) == 0) push_load(order[i], gen_book[order[i - 1]]);
      else push_load(order[i], rand_vector());
    end
    settle();

    random_phase(1, 128, 40, 1'b0);
    random_phase(4, 1, 30, 1'b0);
    random_phase(0, 0, 30, 1'b0);
    random_phase(7, 255, 40, 1'b0);
    random_phase(2, 129, 30, 1'b0);
    random_phase(4, 8, 50, 1'b1);
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0: t = $urandom_range(129, 255);
        1: t = 128;
        2, 3: t = $urandom_range(1, 8);
        default: t = $urandom_range(9, 40);
      endcase
      random_phase($urandom_range(0, 7), t, 65, 1'b0);
    end
    calm = 1'b1;
    random_phase(3, $urandom_range(1, 16), 60, 1'b0);

    if (result_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", result_q.size()));
    $display("sent %0d load beats and %0d quantize beats, checked %0d results",
             n_loads, n_quant, n_results);
    $display("%0d register settings incl. out-of-range values, %0d long output hold-offs",
             n_settings, holds_served);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/vqs_pkg.sv
sv/vqs_cell.sv
sv/vector_quantizer_search_core.sv
test/tb.sv
